FILE: design/jdcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_pkg
// Constants and shared types for the day-number-to-date pipeline.
// ----------------------------------------------------------------------------
package jdcal_pkg;

  localparam int JdW = 39;
  localparam int YearW = 31;

  localparam logic [JdW-1:0] LastJulianDay = 39'd2299160;
  localparam logic [JdW-1:0] First1583Day  = 39'd2299239;
  localparam logic [JdW-1:0] GregEpochDay  = 39'd2159717;
  localparam logic [YearW-1:0] GregEpochYear = 31'd1201;

  // floor(2^49 / 146097): applied to day >> 8, quotient is product >> 41
  localparam logic [31:0] GregRecip = 32'd3853261555;
  // ceil(2^32 / 1461): exact quotient for operands below 2^24
  localparam logic [21:0] Recip1461 = 22'd2939745;

  // Year split result handed to the month stage
  typedef struct packed {
    logic             valid;
    logic [YearW-1:0] year;
    logic             bc;
    logic [8:0]       doy;
    logic             leap;
  } year_split_t;

  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] s;
    case (m)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd59;
      4'd3:    s = 9'd90;
      4'd4:    s = 9'd120;
      4'd5:    s = 9'd151;
      4'd6:    s = 9'd181;
      4'd7:    s = 9'd212;
      4'd8:    s = 9'd243;
      4'd9:    s = 9'd273;
      4'd10:   s = 9'd304;
      4'd11:   s = 9'd334;
      default: s = 9'd365;
    endcase
    if (leap && m >= 4'd2) begin
      s = s + 9'd1;
    end
    return s;
  endfunction

endpackage

FILE: design/jdcal_year.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_year
// Pipelined split of a day number into year, BC flag, day of year and leap flag.
// ----------------------------------------------------------------------------
module jdcal_year (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [jdcal_pkg::JdW-1:0]   julian_day,
  output jdcal_pkg::year_split_t      split
);
  import jdcal_pkg::*;

  // Stage 1: select calendar and offset
  logic            s1_valid, s1_greg;
  logic [JdW-1:0]  s1_d;
  // Stage 2: cycle quotient estimate by reciprocal multiply
  logic            s2_valid, s2_greg;
  logic [JdW-1:0]  s2_d;
  logic [21:0]     s2_q;
  // Stage 3: remainder of the estimate
  logic            s3_valid, s3_greg;
  logic [21:0]     s3_q;
  logic [18:0]     s3_r;
  // Stage 4: corrected quotient and remainder
  logic            s4_valid, s4_greg;
  logic [21:0]     s4_q;
  logic [17:0]     s4_r;
  // Stage 5: century split (gregorian)
  logic            s5_valid, s5_greg;
  logic [21:0]     s5_q;
  logic [1:0]      s5_c;
  logic [15:0]     s5_r;
  // Stage 6: four year block index
  logic            s6_valid, s6_greg;
  logic [21:0]     s6_q;
  logic [1:0]      s6_c;
  logic [4:0]      s6_q4;
  logic [15:0]     s6_r;
  // Stage 7: remainder within the four year block
  logic            s7_valid, s7_greg;
  logic [21:0]     s7_q;
  logic [1:0]      s7_c;
  logic [4:0]      s7_q4;
  logic [10:0]     s7_r4;
  // Stage 8: year within block and day of year
  logic            s8_valid, s8_greg;
  logic [21:0]     s8_q;
  logic [1:0]      s8_c;
  logic [4:0]      s8_q4;
  logic [1:0]      s8_q1;
  logic [8:0]      s8_doy;
  // Stage 9: year assembly
  year_split_t     s9;

  logic             is_julian;
  logic [JdW-1:0]   d_sel;
  logic [30:0]      mul_a;
  logic [31:0]      mul_b;
  logic [62:0]      mul_p;
  logic [21:0]      q_est;
  logic [17:0]      div_c;
  logic [39:0]      qd_p;
  logic [JdW-1:0]   r_raw;
  logic             r_over;
  logic [1:0]       c_n;
  logic [17:0]      c_sub;
  logic [37:0]      q4_p;
  logic [4:0]       q4_n;
  logic [10:0]      r4_n;
  logic [1:0]       q1_n;
  logic [10:0]      doy_n;
  logic [YearW-1:0] y_g;
  logic [12:0]      y_j;
  logic [YearW-1:0] y_n;
  logic             bc_n;
  logic             leap_n;

  assign is_julian = (julian_day < First1583Day);

  always_comb begin
    if (is_julian) begin
      // shift the post-reform tail of 1582 by the ten dropped days
      d_sel = (julian_day <= LastJulianDay) ? julian_day : julian_day + 39'd10;
    end else begin
      d_sel = julian_day - GregEpochDay;
    end
  end

  // One 31 x 32 multiplier serves both calendars; the gregorian estimate
  // is at most one short, the julian one is exact.
  always_comb begin
    if (s1_greg) begin
      mul_a = s1_d[JdW-1:8];
      mul_b = GregRecip;
    end else begin
      mul_a = {9'd0, s1_d[21:0]};
      mul_b = {10'd0, Recip1461};
    end
    mul_p = {32'd0, mul_a} * {31'd0, mul_b};
    q_est = s1_greg ? mul_p[62:41] : mul_p[53:32];
  end

  always_comb begin
    div_c = s2_greg ? 18'd146097 : 18'd1461;
    qd_p  = {18'd0, s2_q} * {22'd0, div_c};
    r_raw = s2_d - qd_p[JdW-1:0];
  end

  assign r_over = s3_greg && (s3_r >= 19'd146097);

  always_comb begin
    c_n = 2'd0;
    if (s4_greg) begin
      if (s4_r >= 18'd109572) c_n = 2'd3;
      else if (s4_r >= 18'd73048) c_n = 2'd2;
      else if (s4_r >= 18'd36524) c_n = 2'd1;
    end
    c_sub = 18'(c_n) * 18'd36524;
  end

  always_comb begin
    q4_p = {22'd0, s5_r} * {16'd0, Recip1461};
    q4_n = s5_greg ? q4_p[36:32] : 5'd0;
  end

  assign r4_n = 11'(s6_r - 16'(s6_q4) * 16'd1461);

  always_comb begin
    q1_n = 2'd0;
    if (s7_greg) begin
      if (s7_r4 >= 11'd1095) q1_n = 2'd3;
      else if (s7_r4 >= 11'd730) q1_n = 2'd2;
      else if (s7_r4 >= 11'd365) q1_n = 2'd1;
    end else begin
      // the leap year leads the julian four year block
      if (s7_r4 >= 11'd1096) q1_n = 2'd3;
      else if (s7_r4 >= 11'd731) q1_n = 2'd2;
      else if (s7_r4 >= 11'd366) q1_n = 2'd1;
    end
    doy_n = s7_r4 - 11'(q1_n) * 11'd365 - {10'd0, (!s7_greg && q1_n != 2'd0)};
  end

  always_comb begin
    y_g = GregEpochYear + 31'(s8_q) * 31'd400 + 31'(s8_c) * 31'd100
        + 31'(s8_q4) * 31'd4 + 31'(s8_q1);
    // four years per block plus the year within the block
    y_j = {s8_q[10:0], s8_q1};
    if (s8_greg) begin
      y_n    = y_g;
      bc_n   = 1'b0;
      leap_n = (s8_q1 == 2'd3) && ((s8_q4 != 5'd24) || (s8_c == 2'd3));
    end else begin
      leap_n = (s8_q1 == 2'd0);
      if (y_j <= 13'd4712) begin
        // no year zero: astronomical year 0 is 1 BC
        y_n  = 31'(13'd4713 - y_j);
        bc_n = 1'b1;
      end else begin
        y_n  = 31'(y_j - 13'd4712);
        bc_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
      s9.valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
      s6_valid <= s5_valid;
      s7_valid <= s6_valid;
      s8_valid <= s7_valid;
      s9.valid <= s8_valid;
    end
    s1_greg <= !is_julian;
    s1_d    <= d_sel;
    s2_greg <= s1_greg;
    s2_d    <= s1_d;
    s2_q    <= q_est;
    s3_greg <= s2_greg;
    s3_q    <= s2_q;
    s3_r    <= r_raw[18:0];
    s4_greg <= s3_greg;
    s4_q    <= r_over ? s3_q + 22'd1 : s3_q;
    s4_r    <= r_over ? 18'(s3_r - 19'd146097) : s3_r[17:0];
    s5_greg <= s4_greg;
    s5_q    <= s4_q;
    s5_c    <= c_n;
    s5_r    <= 16'(s4_r - c_sub);
    s6_greg <= s5_greg;
    s6_q    <= s5_q;
    s6_c    <= s5_c;
    s6_q4   <= q4_n;
    s6_r    <= s5_r;
    s7_greg <= s6_greg;
    s7_q    <= s6_q;
    s7_c    <= s6_c;
    s7_q4   <= s6_q4;
    s7_r4   <= r4_n;
    s8_greg <= s7_greg;
    s8_q    <= s7_q;
    s8_c    <= s7_c;
    s8_q4   <= s7_q4;
    s8_q1   <= q1_n;
    s8_doy  <= doy_n[8:0];
    s9.doy  <= s8_doy;
    s9.leap <= leap_n;
    s9.year <= y_n;
    s9.bc   <= bc_n;
  end

  assign split = s9;

  a_rem: assert property (@(posedge clk) disable iff (rst)
    s4_valid |-> s4_r < 18'd146097) else $error("cycle remainder too large");
  a_jrem: assert property (@(posedge clk) disable iff (rst)
    s4_valid && !s4_greg |-> s4_r < 18'd1461) else $error("julian remainder too large");
  a_q4: assert property (@(posedge clk) disable iff (rst)
    s6_valid |-> s6_q4 <= 5'd24) else $error("block index out of range");
  a_doy: assert property (@(posedge clk) disable iff (rst)
    s9.valid |-> s9.doy <= 9'd365) else $error("day of year out of range");

endmodule

FILE: design/jdcal_month.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_month
// Registered split of day of year into month and day; year and BC flag pass through.
// ----------------------------------------------------------------------------
module jdcal_month (
  input  logic                          clk,
  input  logic                          rst,
  input  jdcal_pkg::year_split_t        split,
  output logic                          done,
  output logic [4:0]                    day_of_month,
  output logic [3:0]                    month_number,
  output logic [jdcal_pkg::YearW-1:0]   year_number,
  output logic                          before_christ
);
  import jdcal_pkg::*;

  logic [3:0] m;
  always_comb begin
    m = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (split.doy >= month_start(4'(i), split.leap)) m = 4'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= split.valid;
    end
    month_number  <= m + 4'd1;
    day_of_month  <= 5'(split.doy - month_start(m, split.leap) + 9'd1);
    year_number   <= split.year;
    before_christ <= split.bc;
  end

  a_month: assert property (@(posedge clk) disable iff (rst)
    done |-> (month_number >= 4'd1 && month_number <= 4'd12)) else $error("bad month");
  a_day: assert property (@(posedge clk) disable iff (rst)
    done |-> day_of_month != 5'd0) else $error("bad day");
  a_bc: assert property (@(posedge clk) disable iff (rst)
    done && before_christ |-> year_number <= 31'd4713) else $error("bad bc year");

endmodule

FILE: design/julian_day_to_calendar_date_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date_core
// Day number to calendar date, ten register stages.
// ----------------------------------------------------------------------------
// done strobes once a start transfer has passed the jdcal_year stages and the jdcal_month output register.
// Throughput: one day number per cycle; busy stays low.
// Reset clears all stage valid bits; no result is in flight afterward.
// The receiver cannot stall: each result shows for one cycle only.
module julian_day_to_calendar_date_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [jdcal_pkg::JdW-1:0]     julian_day,
  output logic                          done,
  output logic [4:0]                    day_of_month,
  output logic [3:0]                    month_number,
  output logic [jdcal_pkg::YearW-1:0]   year_number,
  output logic                          before_christ
);
  import jdcal_pkg::*;

  year_split_t split;

  assign busy = 1'b0;

  jdcal_year u_year (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (start),
    .julian_day (julian_day),
    .split      (split)
  );

  jdcal_month u_month (
    .clk           (clk),
    .rst           (rst),
    .split         (split),
    .done          (done),
    .day_of_month  (day_of_month),
    .month_number  (month_number),
    .year_number   (year_number),
    .before_christ (before_christ)
  );

  a_lat: assert property (@(posedge clk) disable iff (rst)
    $past(start, 10) && !$past(rst, 10) |-> done) else $error("lost transfer");

endmodule

FILE: dv/jdcal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jdcal_checker
// Watches the day-number transfers and the date results of the converter,
// computes the expected calendar date for each accepted day number and
// compares every result with the oldest pending date as one packed value.
// ----------------------------------------------------------------------------
module jdcal_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [jdcal_pkg::JdW-1:0]   julian_day,
  input  logic                        done,
  input  logic [4:0]                  day_of_month,
  input  logic [3:0]                  month_number,
  input  logic [jdcal_pkg::YearW-1:0] year_number,
  input  logic                        before_christ,
  output int                          fail_count,
  output int                          pending_count
);

  typedef struct packed {
    logic [4:0]  dom;
    logic [3:0]  mon;
    logic [30:0] yr;
    logic        bc;
  } cal_date_t;

  cal_date_t pending_dates[$];

  function automatic cal_date_t calc_date(input logic [38:0] jd);
    cal_date_t r;
    longint unsigned src, c, rem, d, q400, q100, q4, q1, y;
    longint ay;
    int doy, m;
    bit leap;
    int starts[13];
    starts = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};
    if (jd < 39'd2299239) begin
      // Julian side; the post-reform tail of 1582 is shifted by ten days
      src = (jd <= 39'd2299160) ? jd : jd + 10;
      c = src / 1461;
      rem = src % 1461;
      if (rem < 366) begin
        ay = -4712 + longint'(c * 4);
        doy = int'(rem);
        leap = 1;
      end else begin
        ay = -4712 + longint'(c * 4) + 1 + longint'((rem - 366) / 365);
        doy = int'((rem - 366) % 365);
        leap = 0;
      end
      if (ay <= 0) begin
        r.yr = 31'(1 - ay);
        r.bc = 1'b1;
      end else begin
        r.yr = 31'(ay);
        r.bc = 1'b0;
      end
    end else begin
      d = jd - 2159717;
      q400 = d / 146097;
      rem = d % 146097;
      q100 = rem / 36524;
      if (q100 == 4) q100 = 3;
      rem -= q100 * 36524;
      q4 = rem / 1461;
      rem %= 1461;
      q1 = rem / 365;
      if (q1 == 4) q1 = 3;
      rem -= q1 * 365;
      y = 1201 + q400 * 400 + q100 * 100 + q4 * 4 + q1;
      doy = int'(rem);
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      r.yr = 31'(y);
      r.bc = 1'b0;
    end
    m = 0;
    while (m < 11 && doy >= starts[m + 1] + ((leap && m + 1 >= 2) ? 1 : 0)) m++;
    r.mon = 4'(m + 1);
    r.dom = 5'(doy - starts[m] - ((leap && m >= 2) ? 1 : 0) + 1);
    return r;
  endfunction

  assign pending_count = pending_dates.size();

  always @(posedge clk) begin
    cal_date_t exp_d;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (start && !busy) pending_dates = {pending_dates, calc_date(julian_day)};
      if (done) begin
        if (pending_dates.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected date result at %0t: got %0d/%0d/%0d bc=%0d",
                     $realtime, day_of_month, month_number, year_number,
                     before_christ);
        end else begin
          exp_d = pending_dates.pop_front();
          if (exp_d !== {day_of_month, month_number, year_number, before_christ}) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("date mismatch: exp %0d/%0d/%0d bc=%0d got %0d/%0d/%0d bc=%0d",
                       exp_d.dom, exp_d.mon, exp_d.yr, exp_d.bc,
                       day_of_month, month_number, year_number, before_christ);
          end
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random day numbers into the converter with random
// gaps and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [38:0] julian_day = '0;
  logic        busy, done, before_christ;
  logic [4:0]  day_of_month;
  logic [3:0]  month_number;
  logic [30:0] year_number;
  int          fail_count, pending_count;
  int          idle_cycles = 0;
  int          gap_pct = 29;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  julian_day_to_calendar_date_core DUT (.*);

  jdcal_checker u_checker (.*);

  // Watchdog: count cycles with no transfer on either side
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_day(input logic [38:0] jd);
    while ($urandom_range(99, 0) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    julian_day <= jd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [38:0] rand_day();
    logic [38:0] v;
    case ($urandom_range(5, 0))
      0: v = 39'($urandom_range(1721424 + 800, 0));
      1: v = 39'($urandom_range(2299300, 2299100));
      2: v = 39'($urandom_range(1721800, 1721000));
      3: v = 39'($urandom_range(3000000, 2299161));
      4: v = 39'({$urandom, $urandom});
      default: v = 39'($urandom_range(32'h7FFF_FFFF, 0));
    endcase
    return v;
  endfunction

  initial begin
    logic [38:0] directed_days[$];
    directed_days = '{39'd0, 39'd365, 39'd366, 39'd1461, 39'd1721423, 39'd1721424,
                      39'd1721058, 39'd1721059, 39'd2299160, 39'd2299161,
                      39'd2299238, 39'd2299239, 39'd2159717, 39'd2451544,
                      39'd2451604, 39'd2415079, 39'd2415080, 39'd2460000,
                      39'h7F_FFFF_FFFF, 39'h7F_FFFF_FFFE, 39'h55_5555_5555,
                      39'h2A_AAAA_AAAA};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed_days[i]) send_day(directed_days[i]);
    for (int i = 0; i < 500; i++) begin
      if (i == 170) gap_pct = 45;
      if (i == 340) gap_pct = 0;
      send_day(rand_day());
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
